>>> rtl/core/rpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared constants, codes and controller/datapath interface types of the
// rational resampler.
// ----------------------------------------------------------------------------
package rpr_pkg;

   localparam int MAX_UP      = 64;
   localparam int MAX_TAPS    = 64;
   localparam int CHANNELS    = 2;
   localparam int STORE_DEPTH = MAX_UP * MAX_TAPS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int HIST_W      = $clog2(MAX_TAPS);
   localparam int PHASE_W     = $clog2(MAX_UP);
   localparam int SAMPLE_W    = 24;
   localparam int COEF_W      = 24;
   localparam int FACTOR_W    = 7;
   localparam int OFFSET_W    = 12;
   localparam int CNT_W       = 48;
   localparam int PRODCNT_W   = CNT_W + FACTOR_W;
   localparam int PROD_W      = SAMPLE_W + COEF_W;
   localparam int ACC_W       = PROD_W + HIST_W + 2;
   localparam int RESULT_CAP  = 64;
   localparam int NCOUNT_W    = $clog2(RESULT_CAP + 1);
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int ROUND_SHIFT = 20;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_FRAME = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UP     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE = 2'd3;

   typedef struct packed {
      logic              coef_write;
      logic              push_frame;
      logic              push_silence;
      logic              set_flush;
      logic              capture;
      logic              div_start;
      logic              div_sel_down;
      logic              load_pos;
      logic              load_step;
      logic              tap_issue;
      logic [HIST_W-1:0] tap;
      logic              capped;
      logic              step;
      logic              out_bypass;
   } cmd_type;

   typedef struct packed {
      logic restart;
      logic div_done;
      logic emit_ok;
      logic bypass;
      logic flushing;
      logic silence_full;
      logic last_tap;
      logic pipe_busy;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/core/rpr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpr_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rpr_pkg::OFFSET_W-1:0]   dividend,
   input  logic [rpr_pkg::FACTOR_W-1:0]   divisor,
   output logic                           done,
   output logic [rpr_pkg::OFFSET_W-1:0]   quotient,
   output logic [rpr_pkg::FACTOR_W-1:0]   remainder
);

   localparam int CW = $clog2(rpr_pkg::OFFSET_W + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [rpr_pkg::OFFSET_W-1:0]  quo_ff, quo_in;
   logic [rpr_pkg::FACTOR_W-1:0]  rem_ff, rem_in;
   logic [rpr_pkg::FACTOR_W:0]    trial;
   logic [rpr_pkg::FACTOR_W:0]    diff;
   logic                          ge;

   assign trial = {rem_ff, quo_ff[rpr_pkg::OFFSET_W-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[rpr_pkg::FACTOR_W-1:0] : trial[rpr_pkg::FACTOR_W-1:0];
         quo_in = {quo_ff[rpr_pkg::OFFSET_W-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(rpr_pkg::OFFSET_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < divisor))
      else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

>>> rtl/core/rpr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpr_dp
// Datapath: registers, coefficient store, sample history, position tracking
// and the two MAC lanes.
// ----------------------------------------------------------------------------
module rpr_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [rpr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rpr_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic [rpr_pkg::ADDR_W-1:0]           req_coef_address,
   input  logic signed [rpr_pkg::COEF_W-1:0]    req_coef_value,
   input  logic signed [rpr_pkg::SAMPLE_W-1:0]  req_sample_ch0,
   input  logic signed [rpr_pkg::SAMPLE_W-1:0]  req_sample_ch1,
   input  rpr_pkg::cmd_type                     cmd,
   output rpr_pkg::status_type                  status,
   output logic signed [rpr_pkg::SAMPLE_W-1:0]  result_ch0,
   output logic signed [rpr_pkg::SAMPLE_W-1:0]  result_ch1
);

   localparam int FW = rpr_pkg::FACTOR_W;
   localparam int PW = rpr_pkg::PHASE_W;
   localparam int HW = rpr_pkg::HIST_W;
   localparam int SW = rpr_pkg::SAMPLE_W;
   localparam int BW = rpr_pkg::PHASE_W + rpr_pkg::FACTOR_W;
   localparam int NC = rpr_pkg::CHANNELS;

   function automatic logic signed [SW-1:0] round_sat(
      input logic signed [rpr_pkg::ACC_W-1:0] acc);
      logic signed [rpr_pkg::ACC_W-1:0]                      biased;
      logic signed [rpr_pkg::ACC_W-rpr_pkg::ROUND_SHIFT-1:0] shifted;
      biased  = acc + rpr_pkg::ACC_W'(1 << (rpr_pkg::ROUND_SHIFT - 1));
      shifted = biased[rpr_pkg::ACC_W-1:rpr_pkg::ROUND_SHIFT];
      if (shifted > (rpr_pkg::ACC_W-rpr_pkg::ROUND_SHIFT)'((1 << (SW - 1)) - 1))
         round_sat = {1'b0, {(SW-1){1'b1}}};
      else if (shifted < -(rpr_pkg::ACC_W-rpr_pkg::ROUND_SHIFT)'(1 << (SW - 1)))
         round_sat = {1'b1, {(SW-1){1'b0}}};
      else
         round_sat = shifted[SW-1:0];
   endfunction

   // configuration registers
   logic [FW-1:0]                  up_ff, down_ff, taps_ff;
   logic [rpr_pkg::OFFSET_W-1:0]   centre_ff;
   logic [FW-1:0]                  eff_up, eff_down, eff_taps;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff     <= FW'(1);
         down_ff   <= FW'(1);
         taps_ff   <= FW'(1);
         centre_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            rpr_pkg::CSR_UP:     up_ff     <= csr_write_data[FW-1:0];
            rpr_pkg::CSR_DOWN:   down_ff   <= csr_write_data[FW-1:0];
            rpr_pkg::CSR_TAPS:   taps_ff   <= csr_write_data[FW-1:0];
            rpr_pkg::CSR_CENTRE: centre_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_up = up_ff;
      if (up_ff == '0) eff_up = FW'(1);
      else if (up_ff > FW'(rpr_pkg::MAX_UP)) eff_up = FW'(rpr_pkg::MAX_UP);
      eff_taps = taps_ff;
      if (taps_ff == '0) eff_taps = FW'(1);
      else if (taps_ff > FW'(rpr_pkg::MAX_TAPS)) eff_taps = FW'(rpr_pkg::MAX_TAPS);
      eff_down = (down_ff == '0) ? FW'(1) : down_ff;
   end

   // shared divider for centre/L and M/L
   logic                          div_done;
   logic [rpr_pkg::OFFSET_W-1:0]  div_quo;
   logic [FW-1:0]                 div_rem;
   logic [rpr_pkg::OFFSET_W-1:0]  div_dividend;

   assign div_dividend = cmd.div_sel_down ? rpr_pkg::OFFSET_W'(eff_down) : centre_ff;

   rpr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (eff_up),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // stream state
   logic                           restart;
   logic                           push;
   logic [rpr_pkg::CNT_W-1:0]      ft_ff, ft_in;
   logic [rpr_pkg::CNT_W-1:0]      posq_ff, posq_in;
   logic [rpr_pkg::PRODCNT_W-1:0]  fl_ff, fl_in;
   logic [rpr_pkg::PRODCNT_W-1:0]  idxm_ff, idxm_in;
   logic [HW-1:0]                  wp_ff, wp_in;
   logic [FW-1:0]                  silence_ff, silence_in;
   logic                           flushing_ff, flushing_in;
   logic [PW-1:0]                  phase_ff, phase_in;
   logic [FW-1:0]                  stepq_ff, stepq_in;
   logic [PW-1:0]                  stepr_ff, stepr_in;
   logic [rpr_pkg::MAX_TAPS-1:0]   hv_ff, hv_in;
   logic [FW:0]                    phase_sum;
   logic [FW:0]                    phase_diff;
   logic                           wrap;

   assign restart = reset || csr_write_enable;
   assign push    = cmd.push_frame || cmd.push_silence;

   assign phase_sum  = (FW+1)'(phase_ff) + (FW+1)'(stepr_ff);
   assign wrap       = phase_sum >= (FW+1)'(eff_up);
   assign phase_diff = phase_sum - (FW+1)'(eff_up);

   always_comb begin
      ft_in       = ft_ff;
      posq_in     = posq_ff;
      fl_in       = fl_ff;
      idxm_in     = idxm_ff;
      wp_in       = wp_ff;
      silence_in  = silence_ff;
      flushing_in = flushing_ff;
      phase_in    = phase_ff;
      stepq_in    = stepq_ff;
      stepr_in    = stepr_ff;
      hv_in       = hv_ff;
      if (push) begin
         ft_in        = ft_ff + rpr_pkg::CNT_W'(1);
         wp_in        = wp_ff + HW'(1);
         hv_in[wp_ff] = 1'b1;
      end
      if (cmd.push_frame)   fl_in = fl_ff + rpr_pkg::PRODCNT_W'(eff_up);
      if (cmd.push_silence) silence_in = silence_ff + FW'(1);
      if (cmd.set_flush)    flushing_in = 1'b1;
      if (cmd.load_pos) begin
         posq_in  = rpr_pkg::CNT_W'(div_quo);
         phase_in = div_rem[PW-1:0];
      end
      if (cmd.load_step) begin
         stepq_in = div_quo[FW-1:0];
         stepr_in = div_rem[PW-1:0];
      end
      if (cmd.step) begin
         phase_in = wrap ? phase_diff[PW-1:0] : phase_sum[PW-1:0];
         posq_in  = posq_ff + rpr_pkg::CNT_W'(stepq_ff) + rpr_pkg::CNT_W'(wrap);
         idxm_in  = idxm_ff + rpr_pkg::PRODCNT_W'(eff_down);
      end
   end

   always_ff @(posedge clock) begin
      if (restart) begin
         ft_ff       <= '0;
         posq_ff     <= '0;
         fl_ff       <= '0;
         idxm_ff     <= '0;
         wp_ff       <= '0;
         silence_ff  <= '0;
         flushing_ff <= 1'b0;
         phase_ff    <= '0;
         stepq_ff    <= '0;
         stepr_ff    <= '0;
         hv_ff       <= '0;
      end else begin
         ft_ff       <= ft_in;
         posq_ff     <= posq_in;
         fl_ff       <= fl_in;
         idxm_ff     <= idxm_in;
         wp_ff       <= wp_in;
         silence_ff  <= silence_in;
         flushing_ff <= flushing_in;
         phase_ff    <= phase_in;
         stepq_ff    <= stepq_in;
         stepr_ff    <= stepr_in;
         hv_ff       <= hv_in;
      end
   end

   // memories and tap addressing
   logic signed [rpr_pkg::COEF_W-1:0]  coef_mem [rpr_pkg::STORE_DEPTH];
   logic signed [SW-1:0]               hist_mem [NC][rpr_pkg::MAX_TAPS];
   logic signed [SW-1:0]               sample_w [NC];
   logic signed [SW-1:0]               sample_ff [NC];
   logic [BW-1:0]                      base_full;
   logic [rpr_pkg::ADDR_W-1:0]         coef_addr;
   logic [HW-1:0]                      hist_addr;

   assign sample_w[0] = req_sample_ch0;
   assign sample_w[1] = req_sample_ch1;

   assign base_full = BW'(phase_ff) * BW'(eff_taps);
   assign coef_addr = rpr_pkg::ADDR_W'(base_full + BW'(cmd.tap));
   // oldest tap sits taps_per_phase entries behind the write pointer
   assign hist_addr = wp_ff - eff_taps[HW-1:0] + cmd.tap;

   // mac pipeline: read, multiply, accumulate
   logic signed [rpr_pkg::COEF_W-1:0]  coef_rd_ff;
   logic signed [SW-1:0]               hist_rd_ff [NC];
   logic                               hv_rd_ff;
   logic                               v1_ff, v2_ff;
   logic                               f1_ff, f2_ff;
   logic signed [rpr_pkg::PROD_W-1:0]  prod_ff [NC];
   logic signed [rpr_pkg::ACC_W-1:0]   acc_ff [NC];

   always_ff @(posedge clock) begin
      if (cmd.coef_write) coef_mem[req_coef_address] <= req_coef_value;
      coef_rd_ff <= coef_mem[coef_addr];
      hv_rd_ff   <= hv_ff[hist_addr];
      f1_ff      <= (cmd.tap == '0);
      f2_ff      <= f1_ff;
      for (int c = 0; c < NC; c++) begin
         if (push) hist_mem[c][wp_ff] <= cmd.push_frame ? sample_w[c] : '0;
         hist_rd_ff[c] <= hist_mem[c][hist_addr];
         if (cmd.capture) sample_ff[c] <= sample_w[c];
         if (v1_ff) prod_ff[c] <= coef_rd_ff * (hv_rd_ff ? hist_rd_ff[c] : SW'(0));
         if (v2_ff) begin
            acc_ff[c] <= f2_ff ? rpr_pkg::ACC_W'(prod_ff[c])
                               : acc_ff[c] + rpr_pkg::ACC_W'(prod_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.tap_issue;
         v2_ff <= v1_ff;
      end
   end

   assign result_ch0 = cmd.out_bypass ? sample_ff[0] : round_sat(acc_ff[0]);
   assign result_ch1 = cmd.out_bypass ? sample_ff[1] : round_sat(acc_ff[1]);

   always_comb begin
      status.restart      = csr_write_enable;
      status.div_done     = div_done;
      status.emit_ok      = (posq_ff == ft_ff - rpr_pkg::CNT_W'(1)) &&
                            (!cmd.capped || (idxm_ff < fl_ff));
      status.bypass       = (eff_up == FW'(1)) && (eff_down == FW'(1));
      status.flushing     = flushing_ff;
      status.silence_full = silence_ff >= eff_taps;
      status.last_tap     = (FW'(cmd.tap) == eff_taps - FW'(1));
      status.pipe_busy    = v1_ff || v2_ff;
   end

   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff < eff_up)
      else $error("output phase outside branch range");

endmodule
`default_nettype wire

>>> rtl/core/rpr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpr_ctrl
// Controller: transaction decode, restart division, tap sequencing and
// output emission loop.
// ----------------------------------------------------------------------------
module rpr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [rpr_pkg::OP_W-1:0]      req_op,
   output logic                          req_stall,
   input  rpr_pkg::status_type           status,
   input  logic                          out_free,
   output rpr_pkg::cmd_type              cmd,
   output logic                          out_load,
   output logic                          out_last
);

   typedef enum logic [10:0] {
      S_IDLE      = 11'b000_0000_0001,
      S_DIVC_GO   = 11'b000_0000_0010,
      S_DIVC_WAIT = 11'b000_0000_0100,
      S_DIVM_GO   = 11'b000_0000_1000,
      S_DIVM_WAIT = 11'b000_0001_0000,
      S_CHECK     = 11'b000_0010_0000,
      S_MAC       = 11'b000_0100_0000,
      S_DRAIN     = 11'b000_1000_0000,
      S_STEP      = 11'b001_0000_0000,
      S_WRITE     = 11'b010_0000_0000,
      S_BYPASS    = 11'b100_0000_0000
   } state_type;

   state_type                       state_ff, state_in;
   logic [rpr_pkg::HIST_W-1:0]      tap_ff, tap_in;
   logic [rpr_pkg::NCOUNT_W-1:0]    n_ff, n_in;
   logic                            capped_ff, capped_in;
   logic                            more;

   assign req_stall = (state_ff != S_IDLE);
   assign more      = status.emit_ok && (n_ff < rpr_pkg::NCOUNT_W'(rpr_pkg::RESULT_CAP));

   always_comb begin
      cmd       = '0;
      cmd.tap   = tap_ff;
      cmd.capped = capped_ff;
      state_in  = state_ff;
      tap_in    = tap_ff;
      n_in      = n_ff;
      capped_in = capped_ff;
      out_load  = 1'b0;
      out_last  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  rpr_pkg::OP_LOAD: cmd.coef_write = 1'b1;
                  rpr_pkg::OP_FRAME: begin
                     if (status.bypass) begin
                        cmd.capture = 1'b1;
                        state_in    = S_BYPASS;
                     end else if (!status.flushing) begin
                        cmd.push_frame = 1'b1;
                        capped_in      = 1'b0;
                        state_in       = S_CHECK;
                     end
                  end
                  rpr_pkg::OP_FLUSH: begin
                     if (!status.bypass) begin
                        cmd.set_flush = 1'b1;
                        if (!status.silence_full) begin
                           cmd.push_silence = 1'b1;
                           capped_in        = 1'b1;
                           state_in         = S_CHECK;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIVC_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVC_WAIT;
         end
         S_DIVC_WAIT: begin
            if (status.div_done) begin
               cmd.load_pos = 1'b1;
               state_in     = S_DIVM_GO;
            end
         end
         S_DIVM_GO: begin
            cmd.div_start    = 1'b1;
            cmd.div_sel_down = 1'b1;
            state_in         = S_DIVM_WAIT;
         end
         S_DIVM_WAIT: begin
            if (status.div_done) begin
               cmd.load_step = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_CHECK: begin
            n_in   = '0;
            tap_in = '0;
            state_in = status.emit_ok ? S_MAC : S_IDLE;
         end
         S_MAC: begin
            cmd.tap_issue = 1'b1;
            if (status.last_tap) state_in = S_DRAIN;
            else tap_in = tap_ff + rpr_pkg::HIST_W'(1);
         end
         S_DRAIN: begin
            if (!status.pipe_busy) state_in = S_STEP;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            n_in     = n_ff + rpr_pkg::NCOUNT_W'(1);
            state_in = S_WRITE;
         end
         S_WRITE: begin
            // position already advanced, so the check sees the next output
            if (out_free) begin
               out_load = 1'b1;
               out_last = !more;
               tap_in   = '0;
               state_in = more ? S_MAC : S_IDLE;
            end
         end
         S_BYPASS: begin
            cmd.out_bypass = 1'b1;
            if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (status.restart) state_in = S_DIVC_GO;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_DIVC_GO;
         tap_ff    <= '0;
         n_ff      <= '0;
         capped_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tap_ff    <= tap_in;
         n_ff      <= n_in;
         capped_ff <= capped_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("output register overwritten while occupied");

   a_run_capped: assert property (@(posedge clock) disable iff (reset)
      n_ff <= rpr_pkg::NCOUNT_W'(rpr_pkg::RESULT_CAP))
      else $error("more outputs than the run limit");

endmodule
`default_nettype wire

>>> rtl/core/polyphase_rational_resampler.sv
`default_nettype none
// a frame passes S_CHECK, S_MAC once per tap, S_DRAIN, S_STEP and S_WRITE for its
//   first output; each further output repeats S_MAC to S_WRITE on the two-lane mac,
//   up to 64 per item; result stalls hold S_WRITE; requests stall until the item
//   is done; loads and dropped items end in S_IDLE, items with no output in S_CHECK
// reset and any register write restart the stream and run two divisions
//   during which no transaction is accepted; coefficients are kept
// ----------------------------------------------------------------------------
// polyphase_rational_resampler
// Two-channel rational L/M polyphase FIR resampler with a coefficient store,
// a controller and a datapath sharing one MAC per channel.
// ----------------------------------------------------------------------------
module polyphase_rational_resampler (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rpr_pkg::OP_W-1:0]             req_op,
   input  logic [rpr_pkg::ADDR_W-1:0]           req_coef_address,
   input  logic signed [rpr_pkg::COEF_W-1:0]    req_coef_value,
   input  logic signed [rpr_pkg::SAMPLE_W-1:0]  req_sample_ch0,
   input  logic signed [rpr_pkg::SAMPLE_W-1:0]  req_sample_ch1,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [rpr_pkg::SAMPLE_W-1:0]  rsp_out_ch0,
   output logic signed [rpr_pkg::SAMPLE_W-1:0]  rsp_out_ch1,
   output logic                                 rsp_last_of_run,
   // register write port
   input  logic                                 csr_write_enable,
   input  logic [rpr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rpr_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   rpr_pkg::cmd_type     cmd;
   rpr_pkg::status_type  status;
   logic                 out_free;
   logic                 out_load;
   logic                 out_last;
   logic signed [rpr_pkg::SAMPLE_W-1:0] result_ch0, result_ch1;

   // output register parts the result channel from the compute loop
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [rpr_pkg::SAMPLE_W-1:0]  rsp_ch0_ff, rsp_ch1_ff;
   logic                                 rsp_last_ff;

   // free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   rpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .out_free  (out_free),
      .cmd       (cmd),
      .out_load  (out_load),
      .out_last  (out_last)
   );

   rpr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_coef_address (req_coef_address),
      .req_coef_value   (req_coef_value),
      .req_sample_ch0   (req_sample_ch0),
      .req_sample_ch1   (req_sample_ch1),
      .cmd              (cmd),
      .status           (status),
      .result_ch0       (result_ch0),
      .result_ch1       (result_ch1)
   );

   // a stalled transaction holds; a taken one empties the register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_ch0_ff  <= result_ch0;
         rsp_ch1_ff  <= result_ch1;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_ch0     = rsp_ch0_ff;
   assign rsp_out_ch1     = rsp_ch1_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule
`default_nettype wire
